@@ hdl/mvrq_pkg.sv @@
package mvrq_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int NUM_CPUS  = 4;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int VR_W      = 64;
	localparam int TS_W      = 16;

	localparam logic [2:0] CMD_ACTIVATE       = 3'd0;
	localparam logic [2:0] CMD_ALERT_ACTIVATE = 3'd1;
	localparam logic [2:0] CMD_RESCHEDULE     = 3'd2;
	localparam logic [2:0] CMD_TICK           = 3'd3;
	localparam logic [2:0] CMD_CREATE         = 3'd4;
	localparam logic [2:0] CMD_KILL           = 3'd5;

	localparam logic [2:0] SLOT_UNUSED       = 3'd0;
	localparam logic [2:0] SLOT_RUNNABLE     = 3'd1;
	localparam logic [2:0] SLOT_RUNNING      = 3'd2;
	localparam logic [2:0] SLOT_SLEEPING     = 3'd3;
	localparam logic [2:0] SLOT_DEEPSLEEPING = 3'd4;
	localparam logic [2:0] SLOT_ZOMBIE       = 3'd5;

	localparam logic CFG_TIMESLICE  = 1'b0;
	localparam logic CFG_FORCE_IDLE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_TICK_WR,
		S_RESCHED,
		S_SCAN,
		S_SCAN_END,
		S_PICK,
		S_RESP
	} seq_state_t;

endpackage

@@ hdl/mvrq_ram.sv @@
module mvrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/min_vruntime_run_queue_scheduler_top.sv @@
// Flow: activate, create, kill and rejected commands go from decode to the result
// state; reschedule also passes resched, scan, scan-end and pick, tick of a busy
// CPU a tick write before them, the scan reading one slot per cycle; force_idle or
// a killed current slot skip the scan. A new command is taken once the result loads.
// Reset: slot states, queued and killed marks, vruntime valid bits and CPU state
// clear at once; the vruntime RAM is not swept, a slot without valid bit reads zero.
module min_vruntime_run_queue_scheduler_top
	import mvrq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // command[2:0], cpu[4:3], proc[8:5], req_state[11:9]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // running_slot[3:0], running_idle[4], switched[5],
	                               // activated[6], fault[7]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	seq_state_t state_q, state_d;

	logic [TS_W-1:0]   timeslice_q;
	logic              force_idle_q;

	logic [2:0]        slot_state_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] queued_q, killed_q, vr_vld_q;
	logic [SLOT_W-1:0] cpu_cur_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] cpu_idle_q;

	logic [2:0]        cmd_q, ns_q;
	logic [1:0]        cpu_q;
	logic [3:0]        proc_q;
	logic [SLOT_W-1:0] cur_q, idx_q, best_q, pend_s1;
	logic              was_idle_q, best_found_q, pend_vld_s1;
	logic [VR_W-1:0]   best_val_q;
	logic              sw_q, act_q, flt_q;
	logic [7:0]        out_q;
	logic              out_vld_q;

	logic              accept, cpu_ok, slot_ok, ns_ok, kill_skip, out_load, last_idx;
	logic [CPU_W-1:0]  cpu_idx;
	logic [SLOT_W-1:0] proc_idx, raddr;
	logic [VR_W-1:0]   rdata, cand, tick_sum;
	logic [2:0]        ps;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	assign cpu_idx  = cpu_q[CPU_W-1:0];
	assign proc_idx = proc_q[SLOT_W-1:0];
	assign cpu_ok   = (32'(cpu_q) < NUM_CPUS);
	assign slot_ok  = (32'(proc_q) < NUM_SLOTS);
	assign ns_ok    = (ns_q == SLOT_RUNNABLE) || (ns_q == SLOT_SLEEPING) ||
	                  (ns_q == SLOT_DEEPSLEEPING) || (ns_q == SLOT_ZOMBIE);
	assign kill_skip = !was_idle_q && killed_q[cur_q] && (ns_q != SLOT_ZOMBIE);
	assign out_load = (state_q == S_RESP) && (!out_vld_q || m_tready);
	assign last_idx = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign ps       = slot_state_q[proc_idx];

	assign raddr    = (state_q == S_DECODE) ? cpu_cur_q[cpu_idx] : idx_q;
	assign tick_sum = (vr_vld_q[cur_q] ? rdata : '0) + VR_W'(timeslice_q);
	assign cand     = vr_vld_q[pend_s1] ? rdata : '0;

	mvrq_ram #(.WIDTH(VR_W), .DEPTH(NUM_SLOTS)) u_vr_ram (
		.clk   (clk),
		.we    (state_q == S_TICK_WR),
		.waddr (cur_q),
		.wdata (tick_sum),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_RESP;
				if (cmd_q == CMD_RESCHEDULE && cpu_ok && ns_ok) begin
					state_d = S_RESCHED;
				end else if (cmd_q == CMD_TICK && cpu_ok) begin
					state_d = cpu_idle_q[cpu_idx] ? S_RESCHED : S_TICK_WR;
				end
			end
			S_TICK_WR:  state_d = S_RESCHED;
			S_RESCHED: begin
				if (kill_skip) state_d = S_RESP;
				else if (force_idle_q) state_d = S_PICK;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (last_idx) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_PICK;
			S_PICK:     state_d = S_RESP;
			S_RESP: begin
				if (out_load) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeslice_q  <= TS_W'(10);
			force_idle_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMESLICE:  timeslice_q  <= cfg_data[TS_W-1:0];
				CFG_FORCE_IDLE: force_idle_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item fields and working registers
	always_ff @(posedge clk) begin
		pend_vld_s1 <= (state_q == S_SCAN);
		pend_s1     <= idx_q;
		if (accept) begin
			cmd_q  <= s_tdata[2:0];
			cpu_q  <= s_tdata[4:3];
			proc_q <= s_tdata[8:5];
			ns_q   <= s_tdata[11:9];
			sw_q   <= 1'b0;
			act_q  <= 1'b0;
			flt_q  <= 1'b0;
		end
		unique case (state_q)
			S_DECODE: begin
				cur_q      <= cpu_cur_q[cpu_idx];
				was_idle_q <= cpu_idle_q[cpu_idx];
				if (cmd_q == CMD_TICK) ns_q <= SLOT_RUNNABLE;
				unique case (cmd_q)
					CMD_ACTIVATE, CMD_ALERT_ACTIVATE: begin
						if (!slot_ok) begin
							flt_q <= 1'b1;
						end else if (ps == SLOT_RUNNING || ps == SLOT_RUNNABLE) begin
						end else if (ps == SLOT_DEEPSLEEPING && cmd_q == CMD_ALERT_ACTIVATE) begin
						end else if (ps == SLOT_SLEEPING || ps == SLOT_UNUSED ||
						             ps == SLOT_DEEPSLEEPING) begin
							flt_q <= queued_q[proc_idx];
							act_q <= 1'b1;
						end else begin
							flt_q <= 1'b1;
						end
					end
					CMD_RESCHEDULE: begin
						if (!cpu_ok || !ns_ok) flt_q <= 1'b1;
					end
					CMD_TICK, CMD_CREATE, CMD_KILL: begin
						if ((cmd_q == CMD_TICK) ? !cpu_ok : !slot_ok) flt_q <= 1'b1;
					end
					default: flt_q <= 1'b1;
				endcase
			end
			S_RESCHED: begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
				if (!was_idle_q && !kill_skip && ns_q == SLOT_RUNNABLE && queued_q[cur_q]) begin
					flt_q <= 1'b1;
				end
			end
			S_SCAN: begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			S_PICK: begin
				sw_q <= best_found_q ? (was_idle_q || cur_q != best_q) : !was_idle_q;
			end
			default: ;
		endcase
		// compare the word read in the previous cycle
		if (pend_vld_s1 && queued_q[pend_s1] && (!best_found_q || cand < best_val_q)) begin
			best_found_q <= 1'b1;
			best_q       <= pend_s1;
			best_val_q   <= cand;
		end
	end

	// slot and CPU state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_state_q[i] <= SLOT_UNUSED;
			end
			queued_q   <= '0;
			killed_q   <= '0;
			vr_vld_q   <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				cpu_cur_q[i] <= '0;
			end
			cpu_idle_q <= '1;
		end else begin
			unique case (state_q)
				S_DECODE: begin
					if (slot_ok) begin
						if ((cmd_q == CMD_ACTIVATE || cmd_q == CMD_ALERT_ACTIVATE) &&
						    (ps == SLOT_SLEEPING || ps == SLOT_UNUSED ||
						     (ps == SLOT_DEEPSLEEPING && cmd_q == CMD_ACTIVATE))) begin
							slot_state_q[proc_idx] <= SLOT_RUNNABLE;
							queued_q[proc_idx]     <= 1'b1;
						end
						if (cmd_q == CMD_CREATE) vr_vld_q[proc_idx] <= 1'b0;
						if (cmd_q == CMD_KILL)   killed_q[proc_idx] <= 1'b1;
					end
				end
				S_TICK_WR: vr_vld_q[cur_q] <= 1'b1;
				S_RESCHED: begin
					if (!was_idle_q && !kill_skip) begin
						slot_state_q[cur_q] <= ns_q;
						if (ns_q == SLOT_RUNNABLE) queued_q[cur_q] <= 1'b1;
					end
				end
				S_PICK: begin
					if (best_found_q) begin
						queued_q[best_q]     <= 1'b0;
						slot_state_q[best_q] <= SLOT_RUNNING;
						cpu_idle_q[cpu_idx]  <= 1'b0;
						cpu_cur_q[cpu_idx]   <= best_q;
					end else begin
						cpu_idle_q[cpu_idx]  <= 1'b1;
						cpu_cur_q[cpu_idx]   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cpu_ok && !cpu_idle_q[cpu_idx]) begin
				out_q[3:0] <= 4'(cpu_cur_q[cpu_idx]);
				out_q[4]   <= 1'b0;
			end else begin
				out_q[3:0] <= 4'd0;
				out_q[4]   <= 1'b1;
			end
			out_q[5] <= sw_q;
			out_q[6] <= act_q;
			out_q[7] <= flt_q;
		end
	end

endmodule

@@ hdl/mvrq_checker.sv @@
module mvrq_checker
	import mvrq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// one word in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	// a result never shows in the cycle right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result word appeared too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0)
		else $error("idle result with nonzero slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> !m_tdata[5])
		else $error("activate result reports a switch");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

endmodule

bind min_vruntime_run_queue_scheduler_top mvrq_checker u_mvrq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
